@@ hw/rtl/psr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psr_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_POINT     = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_DONE      = 2'd2,
        KIND_TRUNCATED = 2'd3
    } kind_t;

    // Record layout
    localparam int unsigned HEADER_WORDS = 11;
    localparam int unsigned HDR_IDX_W    = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_COUNT = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_FLAG  = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST  = 4'(HEADER_WORDS - 1);

    // Longitude wrap, microdegrees
    localparam logic signed [31:0] LON_LIMIT = 32'sd180000000;
    localparam logic signed [31:0] LON_TURN  = 32'sd360000000;

    localparam logic [7:0] MAX_LEVEL_RESET = 8'd255;

    // Output queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        kind_t              result_kind;
        logic signed [31:0] longitude_micro;
        logic signed [31:0] latitude_micro;
        logic               first_of_polygon;
        logic               last_of_polygon;
        logic               closing_point;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/psr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input word channel
interface psr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_word;
    logic               end_of_stream;

    modport source (output valid, output data_word, output end_of_stream, input ready);
    modport sink   (input valid, input data_word, input end_of_stream, output ready);
endinterface

// Result channel
interface psr_out_if;
    logic               valid;
    logic               ready;
    psr_pkg::kind_t     result_kind;
    logic signed [31:0] longitude_micro;
    logic signed [31:0] latitude_micro;
    logic               first_of_polygon;
    logic               last_of_polygon;
    logic               closing_point;

    modport source (output valid, output result_kind, output longitude_micro,
                    output latitude_micro, output first_of_polygon,
                    output last_of_polygon, output closing_point, input ready);
    modport sink   (input valid, input result_kind, input longitude_micro,
                    input latitude_micro, input first_of_polygon,
                    input last_of_polygon, input closing_point, output ready);
endinterface

// Configuration write channel (max_level)
interface psr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/shoreline_polygon_record_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Polygon record parser.
// in_ch carries one 32-bit stream word (or an end-of-stream marker) per word.
// Each record is 11 header words followed by x/y pairs; out_ch carries one
// result per kept point, plus a closing point, empty-polygon marker, or a
// final done / truncated result. cfg_ch writes max_level (reset 255); the
// level is latched when a record's flag word arrives.
// Results are registered in the queue before they reach out_ch. Throughput:
// one input word per cycle; results go into a 4-entry queue and in_ch.ready
// stays high while two free entries remain, so only a stalled receiver slows
// intake. The closing point makes one word produce two results, which the
// queue absorbs.
// After done or truncated the parser stops: further words are accepted and
// dropped until reset. rst_n (asynchronous, active low) empties the queue
// and returns to waiting for the first id word. cfg_ch.ready is always high.
module shoreline_polygon_record_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    psr_in_if.sink    in_ch,
    psr_out_if.source out_ch,
    psr_cfg_if.sink   cfg_ch
);
    import psr_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST_ID,
        PH_NEXT_ID,
        PH_HEADER,
        PH_X,
        PH_Y,
        PH_STOPPED
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   hdr_idx_reg, hdr_idx_next;
    logic [30:0]            points_left_reg, points_left_next;
    logic [30:0]            point_total_reg, point_total_next;
    logic                   kept_reg, kept_next;
    logic signed [31:0]     held_lon_reg, held_lon_next;
    logic signed [31:0]     first_lon_reg, first_lon_next;
    logic signed [31:0]     first_lat_reg, first_lat_next;
    logic [7:0]             max_level_reg;

    result_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]      count_reg;

    logic                   in_fire, out_fire;
    result_t                res0, res1;
    logic [1:0]             n_push;
    logic signed [31:0]     lon_wrap;
    logic                   is_first, is_last, closing;
    logic signed [31:0]     cmp_lon, cmp_lat;

    assign in_ch.ready  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_fire     = out_ch.valid && out_ch.ready;
    assign cfg_ch.ready = 1'b1;

    // Longitude wrap above 180 degrees
    assign lon_wrap = (in_ch.data_word > LON_LIMIT) ? in_ch.data_word - LON_TURN
                                                     : in_ch.data_word;

    // Point position in the line and closing check
    assign is_first = (points_left_reg == point_total_reg);
    assign is_last  = (points_left_reg == 31'd1);
    assign cmp_lon  = is_first ? held_lon_reg : first_lon_reg;
    assign cmp_lat  = is_first ? in_ch.data_word : first_lat_reg;
    assign closing  = is_last && (point_total_reg > 31'd1)
                   && ((cmp_lon != held_lon_reg) || (cmp_lat != in_ch.data_word));

    // Parse step
    always_comb
    begin
        phase_next       = phase_reg;
        hdr_idx_next     = hdr_idx_reg;
        points_left_next = points_left_reg;
        point_total_next = point_total_reg;
        kept_next        = kept_reg;
        held_lon_next    = held_lon_reg;
        first_lon_next   = first_lon_reg;
        first_lat_next   = first_lat_reg;
        res0             = '0;
        res1             = '0;
        n_push           = 2'd0;

        if (in_fire && phase_reg != PH_STOPPED)
        begin
            if (in_ch.end_of_stream)
            begin
                res0.result_kind = (phase_reg == PH_NEXT_ID) ? KIND_DONE : KIND_TRUNCATED;
                n_push           = 2'd1;
                phase_next       = PH_STOPPED;
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST_ID, PH_NEXT_ID:
                    begin
                        phase_next   = PH_HEADER;
                        hdr_idx_next = HDR_COUNT;
                    end
                    PH_HEADER:
                    begin
                        if (hdr_idx_reg == HDR_COUNT)
                            point_total_next = in_ch.data_word[31] ? 31'd0
                                                                   : in_ch.data_word[30:0];
                        else if (hdr_idx_reg == HDR_FLAG)
                            kept_next = (in_ch.data_word[7:0] <= max_level_reg);
                        hdr_idx_next = hdr_idx_reg + HDR_IDX_W'(1);
                        if (hdr_idx_reg == HDR_LAST)
                        begin
                            hdr_idx_next = '0;
                            if (point_total_reg == 31'd0)
                            begin
                                if (kept_reg)
                                begin
                                    res0.result_kind      = KIND_EMPTY;
                                    res0.first_of_polygon = 1'b1;
                                    res0.last_of_polygon  = 1'b1;
                                    n_push                = 2'd1;
                                end
                                phase_next = PH_NEXT_ID;
                            end
                            else
                            begin
                                points_left_next = point_total_reg;
                                phase_next       = PH_X;
                            end
                        end
                    end
                    PH_X:
                    begin
                        held_lon_next = lon_wrap;
                        phase_next    = PH_Y;
                    end
                    PH_Y:
                    begin
                        if (is_first)
                        begin
                            first_lon_next = held_lon_reg;
                            first_lat_next = in_ch.data_word;
                        end
                        if (kept_reg)
                        begin
                            res0.result_kind      = KIND_POINT;
                            res0.longitude_micro  = held_lon_reg;
                            res0.latitude_micro   = in_ch.data_word;
                            res0.first_of_polygon = is_first;
                            res0.last_of_polygon  = is_last && !closing;
                            res1.result_kind      = KIND_POINT;
                            res1.longitude_micro  = cmp_lon;
                            res1.latitude_micro   = cmp_lat;
                            res1.last_of_polygon  = 1'b1;
                            res1.closing_point    = 1'b1;
                            n_push                = closing ? 2'd2 : 2'd1;
                        end
                        points_left_next = points_left_reg - 31'd1;
                        phase_next       = is_last ? PH_NEXT_ID : PH_X;
                    end
                    default:
                    begin
                        phase_next = PH_STOPPED;
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FIRST_ID;
            hdr_idx_reg     <= '0;
            points_left_reg <= '0;
            point_total_reg <= '0;
            kept_reg        <= 1'b0;
            held_lon_reg    <= '0;
            first_lon_reg   <= '0;
            first_lat_reg   <= '0;
            max_level_reg   <= MAX_LEVEL_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            hdr_idx_reg     <= hdr_idx_next;
            points_left_reg <= points_left_next;
            point_total_reg <= point_total_next;
            kept_reg        <= kept_next;
            held_lon_reg    <= held_lon_next;
            first_lon_reg   <= first_lon_next;
            first_lat_reg   <= first_lat_next;
            if (cfg_ch.valid)
                max_level_reg <= cfg_ch.data;
        end
    end

    // Result queue payload
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (n_push == 2'd2)
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= res1;
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(n_push) - QCNT_W'(out_fire);
        end
    end

    // Output word
    assign out_ch.valid            = (count_reg != '0);
    assign out_ch.result_kind      = queue_reg[rd_ptr_reg].result_kind;
    assign out_ch.longitude_micro  = queue_reg[rd_ptr_reg].longitude_micro;
    assign out_ch.latitude_micro   = queue_reg[rd_ptr_reg].latitude_micro;
    assign out_ch.first_of_polygon = queue_reg[rd_ptr_reg].first_of_polygon;
    assign out_ch.last_of_polygon  = queue_reg[rd_ptr_reg].last_of_polygon;
    assign out_ch.closing_point    = queue_reg[rd_ptr_reg].closing_point;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import psr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 380;
    localparam int PHASE_COUNT   = 5;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;

    // Parser position, mirrored on the testbench side
    typedef enum {
        ST_FIRST_ID,
        ST_NEXT_ID,
        ST_HEADER,
        ST_X,
        ST_Y,
        ST_STOPPED
    } parse_state_t;

    // Tracks the parser and holds the results still owed by the block
    class polygon_scoreboard;
        logic [7:0]         level;
        parse_state_t       state;
        int                 hdr_idx;
        int unsigned        point_total;
        int unsigned        points_left;
        bit                 kept;
        logic signed [31:0] held_lon;
        logic signed [31:0] first_lon;
        logic signed [31:0] first_lat;
        result_t            due_results[$];
        int                 mismatches;

        function new();
            level       = MAX_LEVEL_RESET;
            state       = ST_FIRST_ID;
            hdr_idx     = 0;
            point_total = 0;
            points_left = 0;
            kept        = 1'b0;
            held_lon    = '0;
            first_lon   = '0;
            first_lat   = '0;
            mismatches  = 0;
        endfunction

        function void set_level(logic [7:0] v);
            level = v;
        endfunction

        function int due_count();
            return due_results.size();
        endfunction

        // Work out what one accepted word makes the block emit
        function void predict_from_word(logic signed [31:0] w, logic eos);
            result_t r;
            bit      is_first;
            bit      is_last;
            bit      add_close;
            if (state == ST_STOPPED)
            begin
                return;
            end
            r = '0;
            if (eos)
            begin
                r.result_kind = (state == ST_NEXT_ID) ? KIND_DONE : KIND_TRUNCATED;
                due_results.push_back(r);
                state = ST_STOPPED;
                return;
            end
            case (state)
                ST_FIRST_ID, ST_NEXT_ID:
                begin
                    state   = ST_HEADER;
                    hdr_idx = 1;
                end
                ST_HEADER:
                begin
                    if (hdr_idx == HDR_COUNT)
                        point_total = (w < 0) ? 0 : w;
                    else if (hdr_idx == HDR_FLAG)
                        kept = (w[7:0] <= level);
                    hdr_idx++;
                    if (hdr_idx >= HEADER_WORDS)
                    begin
                        hdr_idx = 0;
                        if (point_total == 0)
                        begin
                            if (kept)
                            begin
                                r.result_kind      = KIND_EMPTY;
                                r.first_of_polygon = 1'b1;
                                r.last_of_polygon  = 1'b1;
                                due_results.push_back(r);
                            end
                            state = ST_NEXT_ID;
                        end
                        else
                        begin
                            points_left = point_total;
                            state       = ST_X;
                        end
                    end
                end
                ST_X:
                begin
                    held_lon = (w > LON_LIMIT) ? w - LON_TURN : w;
                    state    = ST_Y;
                end
                ST_Y:
                begin
                    is_first = (points_left == point_total);
                    is_last  = (points_left == 1);
                    if (is_first)
                    begin
                        first_lon = held_lon;
                        first_lat = w;
                    end
                    if (kept)
                    begin
                        // closing copy only when a multi-point line is left open
                        add_close = is_last && point_total > 1 &&
                                    (first_lon != held_lon || first_lat != w);
                        r.result_kind      = KIND_POINT;
                        r.longitude_micro  = held_lon;
                        r.latitude_micro   = w;
                        r.first_of_polygon = is_first;
                        r.last_of_polygon  = is_last && !add_close;
                        due_results.push_back(r);
                        if (add_close)
                        begin
                            r.longitude_micro  = first_lon;
                            r.latitude_micro   = first_lat;
                            r.first_of_polygon = 1'b0;
                            r.last_of_polygon  = 1'b1;
                            r.closing_point    = 1'b1;
                            due_results.push_back(r);
                        end
                    end
                    points_left--;
                    state = (points_left == 0) ? ST_NEXT_ID : ST_X;
                end
                default:
                    state = ST_STOPPED;
            endcase
        endfunction

        function void cmp_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one result against the oldest one owed
        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d lon %0d lat %0d",
                         $time, got.result_kind, got.longitude_micro, got.latitude_micro);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            cmp_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            cmp_field("longitude_micro", want.longitude_micro, got.longitude_micro);
            cmp_field("latitude_micro", want.latitude_micro, got.latitude_micro);
            cmp_field("first_of_polygon", 32'(want.first_of_polygon),
                      32'(got.first_of_polygon));
            cmp_field("last_of_polygon", 32'(want.last_of_polygon),
                      32'(got.last_of_polygon));
            cmp_field("closing_point", 32'(want.closing_point), 32'(got.closing_point));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    psr_in_if  in_ch();
    psr_out_if out_ch();
    psr_cfg_if cfg_ch();

    shoreline_polygon_record_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    polygon_scoreboard sb = new();

    bit         idle_on  = 1'b1;
    bit         stall_on = 1'b1;
    bit         hold_req = 1'b0;
    logic [7:0] level_now = MAX_LEVEL_RESET;
    int         words_sent;
    int         records_sent;
    int         records_skipped;
    int         n_points;
    int         n_closing;
    int         n_empty;
    int         n_done;
    int         n_trunc;
    int         cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= !(stall_on && $urandom_range(0, 99) < 9);
                @(posedge clk);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.result_kind      = out_ch.result_kind;
            got.longitude_micro  = out_ch.longitude_micro;
            got.latitude_micro   = out_ch.latitude_micro;
            got.first_of_polygon = out_ch.first_of_polygon;
            got.last_of_polygon  = out_ch.last_of_polygon;
            got.closing_point    = out_ch.closing_point;
            case (got.result_kind)
                KIND_POINT:     if (got.closing_point) n_closing++; else n_points++;
                KIND_EMPTY:     n_empty++;
                KIND_DONE:      n_done++;
                KIND_TRUNCATED: n_trunc++;
                default:        ;
            endcase
            sb.check_result(got);
        end
    end

    // Offer one word, with an occasional idle cycle first
    task automatic send_word(input logic signed [31:0] w, input logic eos);
        if (idle_on && $urandom_range(0, 99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_word     <= w;
        in_ch.end_of_stream <= eos;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.predict_from_word(w, eos);
        words_sent++;
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.due_count() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_level(input logic [7:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.set_level(v);
        level_now = v;
        cfg_ch.valid <= 1'b0;
    endtask

    // Coordinate word: mostly plausible, often at the wrap edge or extremes
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 6))
            0: return LON_LIMIT + 32'($urandom_range(0, 4)) - 32'd2;
            1: return -LON_LIMIT + 32'($urandom_range(0, 4)) - 32'd2;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return $urandom;
            4: return LON_TURN + 32'($urandom_range(0, 4)) - 32'd2;
            default: return 32'($urandom_range(0, 360000000)) - 32'd90000000;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return 32'sd0;
        if (sel < 14)
            return 32'sd0 - 32'($urandom_range(1, 1000));
        if (sel < 16)
            return 32'h8000_0000;
        if (sel < 95)
            return 32'($urandom_range(1, 8));
        return 32'($urandom_range(9, 40));
    endfunction

    // Level near the current limit so both sides of the compare show up
    function automatic logic [7:0] pick_level();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            return level_now;
        if (sel == 1 && level_now != 8'hFF)
            return level_now + 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    // Lay out one record: header then x/y pairs, optionally closed by the sender
    task automatic build_record(input logic signed [31:0] count_word,
                                input logic [7:0] lvl, input bit closed,
                                output logic signed [31:0] words[$]);
        int                 npts;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        words = {};
        npts  = (count_word < 0) ? 0 : count_word;
        words.push_back($urandom);
        words.push_back(count_word);
        words.push_back({24'($urandom), lvl});
        repeat (HEADER_WORDS - 3) words.push_back($urandom);
        x0 = pick_coord();
        y0 = pick_coord();
        for (int i = 0; i < npts; i++)
        begin
            if (i == 0)
            begin
                words.push_back(x0);
                words.push_back(y0);
            end
            else if (closed && i == npts - 1)
            begin
                // same point after the wrap, sometimes written the other way
                if (x0 > LON_LIMIT && $urandom_range(0, 1))
                    words.push_back(x0 - LON_TURN);
                else
                    words.push_back(x0);
                words.push_back(y0);
            end
            else
            begin
                words.push_back(pick_coord());
                words.push_back(pick_coord());
            end
        end
    endtask

    task automatic send_random_record();
        logic signed [31:0] words[$];
        logic [7:0]         lvl;
        lvl = pick_level();
        build_record(pick_count(), lvl, $urandom_range(0, 99) < 35, words);
        records_sent++;
        if (lvl > level_now)
            records_skipped++;
        foreach (words[i]) send_word(words[i], 1'b0);
    endtask

    // Stimulus
    initial
    begin
        logic signed [31:0] words[$];
        int                 cut;
        bit                 clean_end;

        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_word     = '0;
        in_ch.end_of_stream = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: most negative count gives an empty marker,
        // then a one-point polygon at the word extremes
        build_record(32'h8000_0000, 8'h00, 1'b0, words);
        foreach (words[i]) send_word(words[i], 1'b0);
        build_record(32'sd1, 8'hFF, 1'b0, words);
        words[HEADER_WORDS]     = 32'h7FFF_FFFF;
        words[HEADER_WORDS + 1] = 32'h8000_0000;
        foreach (words[i]) send_word(words[i], 1'b0);
        records_sent += 2;

        // Random records across several level limits
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                settle();
                case (p)
                    1:       write_level(8'h00);
                    2:       write_level(8'($urandom_range(1, 254)));
                    3:       write_level(8'hFF);
                    default: write_level(8'($urandom_range(0, 255)));
                endcase
            end
            // phase 3 runs with no idling on either side
            idle_on  = (p != 3);
            stall_on = (p != 3);
            if (p == 0)
                hold_req = 1'b1;
            while (words_sent < (p + 1) * PHASE_WORDS)
                send_random_record();
        end

        // End the stream cleanly or in the middle of a record
        clean_end = $urandom_range(0, 1);
        if (!clean_end)
        begin
            build_record(32'sd3, 8'h00, 1'b0, words);
            cut = $urandom_range(1, words.size() - 1);
            for (int i = 0; i < cut; i++)
                send_word(words[i], 1'b0);
        end
        send_word($urandom, 1'b1);

        // The parser has stopped; these words must be dropped
        repeat (4) send_word($urandom, 1'($urandom_range(0, 1)));
        settle();

        $display("Sent %0d words in %0d records (%0d above the level limit), stream %s.",
                 words_sent, records_sent, records_skipped,
                 clean_end ? "closed cleanly" : "cut short");
        $display("Checked %0d points, %0d closing points, %0d empty polygons, %0d done, %0d trunc.",
                 n_points, n_closing, n_empty, n_done, n_trunc);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
